@@ rtl/core/asa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asa_pkg
// shared widths, register indexes and the cordic arctangent table
// ----------------------------------------------------------------------------
package asa_pkg;

  localparam int ZFRAC     = 16;
  localparam int TABLE_LEN = 24;
  localparam int XW        = 34;
  localparam int PW        = 50;
  localparam int ZW        = 26;
  localparam int MAGW      = 23;
  localparam int DW        = 20;
  localparam int QMAXW     = 17;
  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);
  localparam logic [QMAXW-1:0] PULSE_MAX = 17'd131071;

  localparam logic [1:0] CFG_WHEELBASE = 2'd0;
  localparam logic [1:0] CFG_TRACK     = 2'd1;
  localparam logic [1:0] CFG_DPP       = 2'd2;

  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0: r = 26'sd2949120;
      1: r = 26'sd1740967;
      2: r = 26'sd919879;
      3: r = 26'sd466945;
      4: r = 26'sd234379;
      5: r = 26'sd117304;
      6: r = 26'sd58666;
      7: r = 26'sd29335;
      8: r = 26'sd14668;
      9: r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      20: r = 26'sd4;
      21: r = 26'sd2;
      22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/asa_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asa stream interfaces
// command and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface asa_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] yaw_deg;
  modport source (output valid, output yaw_deg, input ready);
  modport sink   (input valid, input yaw_deg, output ready);
endinterface

interface asa_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_angle_q8;
  logic signed [15:0] left_angle_q8;
  logic signed [17:0] right_pulses;
  logic signed [17:0] left_pulses;
  modport source (output valid, output right_angle_q8, output left_angle_q8,
                  output right_pulses, output left_pulses, input ready);
  modport sink   (input valid, input right_angle_q8, input left_angle_q8,
                  input right_pulses, input left_pulses, output ready);
endinterface
`default_nettype wire

@@ rtl/core/asa_rot_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asa_rot_cordic
// saturates the yaw and runs a pipelined rotation cordic for sin and cos
// ----------------------------------------------------------------------------
module asa_rot_cordic import asa_pkg::*; #(
  parameter int STAGES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pipe_ctl_t            ctl_i,
  input  wire logic signed [7:0]    yaw_i,
  output logic                      valid_o,
  output logic                      zero_o,
  output logic signed [XW-1:0]      cos_o,
  output logic signed [XW-1:0]      sin_o
);

  logic                 v_q [0:STAGES];
  logic                 zf_q [0:STAGES];
  logic signed [XW-1:0] x_q [0:STAGES];
  logic signed [XW-1:0] y_q [0:STAGES];
  logic signed [ZW-1:0] z_q [0:STAGES];
  logic signed [7:0]    yaw_sat;

  always_comb begin
    yaw_sat = yaw_i;
    if (yaw_i > 8'sd89) yaw_sat = 8'sd89;
    if (yaw_i < -8'sd89) yaw_sat = -8'sd89;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      zf_q[0] <= (yaw_sat == 8'sd0);
      x_q[0]  <= XW'(64'sd1 << 30);
      y_q[0]  <= '0;
      z_q[0]  <= {{(ZW-8-ZFRAC){yaw_sat[7]}}, yaw_sat, {ZFRAC{1'b0}}};
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        zf_q[i+1] <= zf_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q16(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q16(i);
        end
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign zero_o  = zf_q[STAGES];
  assign cos_o   = x_q[STAGES];
  assign sin_o   = y_q[STAGES];

endmodule
`default_nettype wire

@@ rtl/core/asa_ratio.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asa_ratio
// forms the numerator and both denominators from sin, cos and the geometry
// ----------------------------------------------------------------------------
module asa_ratio import asa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pipe_ctl_t            ctl_i,
  input  wire logic                 zero_i,
  input  wire logic signed [XW-1:0] cos_i,
  input  wire logic signed [XW-1:0] sin_i,
  input  wire logic [11:0]          wheelbase_i,
  input  wire logic [11:0]          track_i,
  output logic                      valid_o,
  output logic signed [PW-1:0]      num_o,
  output logic signed [PW-1:0]      den_r_o,
  output logic signed [PW-1:0]      den_l_o
);

  localparam int MW = XW + 13;

  logic signed [12:0]   l_s, t_s;
  logic signed [MW-1:0] lcs_q, tsn_q, lsn_q;
  logic                 zf_q, v1_q, v2_q;
  logic signed [PW-1:0] lcs_x, tsn_x, lsn_x;

  assign l_s = $signed({1'b0, wheelbase_i});
  assign t_s = $signed({1'b0, track_i});
  assign lcs_x = PW'(lcs_q);
  assign tsn_x = PW'(tsn_q);
  assign lsn_x = PW'(lsn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      lcs_q <= l_s * cos_i;
      tsn_q <= t_s * sin_i;
      lsn_q <= l_s * sin_i;
      zf_q  <= zero_i;
      if (zf_q) begin
        num_o   <= '0;
        den_r_o <= '0;
        den_l_o <= '0;
      end else begin
        num_o   <= lsn_x <<< 1;
        den_r_o <= lcs_x - tsn_x;
        den_l_o <= lcs_x + tsn_x;
      end
    end
  end

  assign valid_o = v2_q;

endmodule
`default_nettype wire

@@ rtl/core/asa_vec_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asa_vec_cordic
// pipelined vectoring cordic giving atan(num/den) in degrees, clamped to 90
// ----------------------------------------------------------------------------
module asa_vec_cordic import asa_pkg::*; #(
  parameter int STAGES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pipe_ctl_t            ctl_i,
  input  wire logic signed [PW-1:0] num_i,
  input  wire logic signed [PW-1:0] den_i,
  output logic                      valid_o,
  output logic signed [ZW-1:0]      angle_o
);

  logic                 v_q [0:STAGES+1];
  logic                 sp_q [0:STAGES];
  logic signed [ZW-1:0] spz_q [0:STAGES];
  logic signed [PW-1:0] x_q [0:STAGES];
  logic signed [PW-1:0] y_q [0:STAGES];
  logic signed [ZW-1:0] z_q [0:STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      sp_q[0] <= (den_i == '0);
      if (num_i > 0) spz_q[0] <= DEG90;
      else if (num_i < 0) spz_q[0] <= -DEG90;
      else spz_q[0] <= '0;
      if (den_i < 0) begin
        x_q[0] <= -den_i;
        y_q[0] <= -num_i;
      end else begin
        x_q[0] <= den_i;
        y_q[0] <= num_i;
      end
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [PW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        sp_q[i+1]  <= sp_q[i];
        spz_q[i+1] <= spz_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_q16(i);
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_q16(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[STAGES+1] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[STAGES+1] <= v_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      if (sp_q[STAGES]) angle_o <= spz_q[STAGES];
      else if (z_q[STAGES] > DEG90) angle_o <= DEG90;
      else if (z_q[STAGES] < -DEG90) angle_o <= -DEG90;
      else angle_o <= z_q[STAGES];
    end
  end

  assign valid_o = v_q[STAGES+1];

endmodule
`default_nettype wire

@@ rtl/core/asa_pulse_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// asa_pulse_div
// pipelined restoring divider turning an angle into a saturated pulse count
// ----------------------------------------------------------------------------
module asa_pulse_div import asa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pipe_ctl_t            ctl_i,
  input  wire logic signed [ZW-1:0] angle_i,
  input  wire logic [15:0]          side_i,
  input  wire logic [DW-1:0]        dpp_i,
  output logic                      valid_o,
  output logic [15:0]               side_o,
  output logic signed [17:0]        pulses_o
);

  logic              v_q [0:MAGW+1];
  logic              neg_q [0:MAGW];
  logic              zf_q [0:MAGW];
  logic [15:0]       sd_q [0:MAGW];
  logic [MAGW-1:0]   m_q [0:MAGW];
  logic [MAGW-1:0]   q_q [0:MAGW];
  logic [DW-1:0]     r_q [0:MAGW];
  logic signed [ZW-1:0] mag_s;
  logic [QMAXW-1:0]  p_sat;

  assign mag_s = (angle_i < 0) ? -angle_i : angle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      neg_q[0] <= angle_i < 0;
      zf_q[0]  <= angle_i == '0;
      sd_q[0]  <= side_i;
      m_q[0]   <= mag_s[MAGW-1:0];
      q_q[0]   <= '0;
      r_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < MAGW; k++) begin : g_bit
    logic [DW:0] trial;
    assign trial = {r_q[k], m_q[k][MAGW-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        neg_q[k+1] <= neg_q[k];
        zf_q[k+1]  <= zf_q[k];
        sd_q[k+1]  <= sd_q[k];
        m_q[k+1]   <= {m_q[k][MAGW-2:0], 1'b0};
        if (trial >= {1'b0, dpp_i}) begin
          r_q[k+1] <= DW'(trial - {1'b0, dpp_i});
          q_q[k+1] <= {q_q[k][MAGW-2:0], 1'b1};
        end else begin
          r_q[k+1] <= trial[DW-1:0];
          q_q[k+1] <= {q_q[k][MAGW-2:0], 1'b0};
        end
      end
    end
  end

  assign p_sat = (q_q[MAGW] > MAGW'(PULSE_MAX)) ? PULSE_MAX : q_q[MAGW][QMAXW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[MAGW+1] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[MAGW+1] <= v_q[MAGW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      side_o <= sd_q[MAGW];
      if (zf_q[MAGW]) pulses_o <= '0;
      else if (neg_q[MAGW]) pulses_o <= -$signed({1'b0, p_sat});
      else pulses_o <= $signed({1'b0, p_sat});
    end
  end

  assign valid_o = v_q[MAGW+1];

endmodule
`default_nettype wire

@@ rtl/core/ackermann_steering_angles_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ackermann_steering_angles_top
// yaw command to Ackermann wheel angles and stepper targets
// ----------------------------------------------------------------------------
// One command is accepted every cycle while the output is not stalled. The
// stages are an entry stage and one rotation cordic stage per table step,
// two ratio stages (products, then sums and difference), and one vectoring
// cordic stage per table step plus entry and clamp stages. They are
// followed by one divider stage per quotient bit (23) plus entry and output
// stages. A stalled output holds the whole pipeline in place.
module ackermann_steering_angles_top import asa_pkg::*; #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_wdata_i,
  asa_in_if.sink           in_i,
  asa_out_if.source        out_o
);

  localparam int N  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int SH = ZFRAC - ANGLE_FRAC_BITS;

  logic [11:0]   wheelbase_q, track_q;
  logic [DW-1:0] dpp_q;
  pipe_ctl_t     ctl_in, ctl_rot, ctl_rat, ctl_vec, ctl_vl;
  logic          en;

  logic                 rot_valid, rot_zero;
  logic signed [XW-1:0] cs, sn;
  logic                 rat_valid;
  logic signed [PW-1:0] num, den_r, den_l;
  logic                 vr_valid, vl_valid, dr_valid, dl_valid;
  logic signed [ZW-1:0] zr, zl_raw, zl;
  logic [15:0]          ar, al, ar_out, al_out;
  logic signed [17:0]   pr, pl;

  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheelbase_q <= 12'd300;
      track_q     <= 12'd250;
      dpp_q       <= 20'd7373;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WHEELBASE: wheelbase_q <= cfg_wdata_i[11:0];
        CFG_TRACK:     track_q     <= cfg_wdata_i[11:0];
        CFG_DPP:       dpp_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ctl_in  = '{en: en, valid: in_i.valid};
  assign ctl_rot = '{en: en, valid: rot_valid};
  assign ctl_rat = '{en: en, valid: rat_valid};
  assign ctl_vec = '{en: en, valid: vr_valid};
  assign ctl_vl  = '{en: en, valid: vl_valid};

  asa_rot_cordic #(.STAGES(N)) u_rot (
    .clk_i, .rst_ni, .ctl_i(ctl_in), .yaw_i(in_i.yaw_deg),
    .valid_o(rot_valid), .zero_o(rot_zero), .cos_o(cs), .sin_o(sn)
  );

  asa_ratio u_ratio (
    .clk_i, .rst_ni, .ctl_i(ctl_rot), .zero_i(rot_zero), .cos_i(cs), .sin_i(sn),
    .wheelbase_i(wheelbase_q), .track_i(track_q),
    .valid_o(rat_valid), .num_o(num), .den_r_o(den_r), .den_l_o(den_l)
  );

  asa_vec_cordic #(.STAGES(N)) u_vec_r (
    .clk_i, .rst_ni, .ctl_i(ctl_rat), .num_i(num), .den_i(den_r),
    .valid_o(vr_valid), .angle_o(zr)
  );

  asa_vec_cordic #(.STAGES(N)) u_vec_l (
    .clk_i, .rst_ni, .ctl_i(ctl_rat), .num_i(num), .den_i(den_l),
    .valid_o(vl_valid), .angle_o(zl_raw)
  );

  assign zl = -zl_raw;

  if (SH == 0) begin : g_noround
    assign ar = zr[15:0];
    assign al = zl[15:0];
  end else begin : g_round
    logic signed [ZW:0] rr, rl;
    assign rr = ((ZW+1)'(zr) + (ZW+1)'(1 << (SH - 1))) >>> SH;
    assign rl = ((ZW+1)'(zl) + (ZW+1)'(1 << (SH - 1))) >>> SH;
    assign ar = rr[15:0];
    assign al = rl[15:0];
  end

  asa_pulse_div u_div_r (
    .clk_i, .rst_ni, .ctl_i(ctl_vec), .angle_i(zr), .side_i(ar), .dpp_i(dpp_q),
    .valid_o(dr_valid), .side_o(ar_out), .pulses_o(pr)
  );

  asa_pulse_div u_div_l (
    .clk_i, .rst_ni, .ctl_i(ctl_vl), .angle_i(zl), .side_i(al),
    .dpp_i(dpp_q), .valid_o(dl_valid), .side_o(al_out), .pulses_o(pl)
  );

  assign out_o.valid          = dr_valid;
  assign out_o.right_angle_q8 = $signed(ar_out);
  assign out_o.left_angle_q8  = $signed(al_out);
  assign out_o.right_pulses   = pr;
  assign out_o.left_pulses    = pl;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dr_valid == dl_valid && vr_valid == vl_valid)
    else $error("wheel lanes out of step");

  a_right_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.right_pulses < 0 |-> out_o.right_angle_q8 <= 0)
    else $error("right pulse sign disagrees with angle");

  a_left_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.left_pulses > 0 |-> out_o.left_angle_q8 >= 0)
    else $error("left pulse sign disagrees with angle");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.right_pulses != -18'sd131072 &&
                    out_o.left_pulses != -18'sd131072)
    else $error("pulse count beyond saturation");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ackermann_steering_angles_top. Yaw commands go in
// under random gaps and output stalls. Every result is compared field by
// field with a bit-exact model of the cordic and divider arithmetic, across
// several wheelbase, track and pulse-size settings.
// ----------------------------------------------------------------------------
module tb_top;
  import asa_pkg::*;

  typedef struct packed {
    logic signed [15:0] right_angle_q8;
    logic signed [15:0] left_angle_q8;
    logic signed [17:0] right_pulses;
    logic signed [17:0] left_pulses;
  } wheel_cmd_t;

  typedef struct {
    logic signed [7:0] yaw;
    bit                typed;
    wheel_cmd_t        want;
  } yaw_row_t;

  localparam int NSTAGE   = 16;
  localparam int NPHASE   = 7;
  localparam int PER_PHASE = 130;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [19:0] cfg_wdata_i;

  asa_in_if  in_if ();
  asa_out_if out_if ();

  ackermann_steering_angles_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  longint     wheelbase;
  longint     track;
  longint     dpp;
  wheel_cmd_t pending_cmds[$];
  int         n_errors;
  int         n_results;
  int         n_sent;
  bit         calm;

  longint arctan_q16[NSTAGE] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                 58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                 229, 115};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint vector_atan(longint num, longint den);
    longint x, y, z, dx, dy;
    z = 0;
    if (den == 0) return (num > 0) ? (90 <<< 16) : (num < 0) ? -(90 <<< 16) : 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    x = den;
    y = num;
    for (int i = 0; i < NSTAGE; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_q16[i];
      end else begin
        x -= dx; y += dy; z -= arctan_q16[i];
      end
    end
    if (z > (90 <<< 16)) z = 90 <<< 16;
    if (z < -(90 <<< 16)) z = -(90 <<< 16);
    return z;
  endfunction

  function automatic longint angle_to_pulses(longint z);
    longint mag, p;
    mag = (z < 0) ? -z : z;
    if (mag == 0) return 0;
    p = (dpp == 0) ? 131071 : mag / dpp;
    if (p > 131071) p = 131071;
    return (z < 0) ? -p : p;
  endfunction

  function automatic wheel_cmd_t steer_angles(logic signed [7:0] yaw_in);
    longint yaw, x, y, z, dx, dy, num, zr, zl;
    wheel_cmd_t r;
    yaw = yaw_in;
    zr = 0;
    zl = 0;
    if (yaw > 89) yaw = 89;
    if (yaw < -89) yaw = -89;
    if (yaw != 0) begin
      x = 64'sd1 <<< 30;
      y = 0;
      z = yaw <<< 16;
      for (int i = 0; i < NSTAGE; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_q16[i];
        end else begin
          x += dx; y -= dy; z += arctan_q16[i];
        end
      end
      num = 2 * wheelbase * y;
      zr = vector_atan(num, wheelbase * x - track * y);
      zl = -vector_atan(num, wheelbase * x + track * y);
    end
    r.right_angle_q8 = 16'((zr + 128) >>> 8);
    r.left_angle_q8  = 16'((zl + 128) >>> 8);
    r.right_pulses   = 18'(angle_to_pulses(zr));
    r.left_pulses    = 18'(angle_to_pulses(zl));
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with the write done
  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WHEELBASE) wheelbase = val[11:0];
    else if (idx == CFG_TRACK) track = val[11:0];
    else if (idx == CFG_DPP) dpp = val;
    @(negedge clk_i);
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_yaw(logic signed [7:0] yaw, bit typed, wheel_cmd_t want);
    while (!calm && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.yaw_deg <= yaw;
    do @(posedge clk_i); while (!in_if.ready);
    pending_cmds.push_back(typed ? want : steer_angles(yaw));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (pending_cmds.size() == 0);
    repeat (120) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    wheel_cmd_t got, exp_cmd;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.right_angle_q8 = out_if.right_angle_q8;
      got.left_angle_q8  = out_if.left_angle_q8;
      got.right_pulses   = out_if.right_pulses;
      got.left_pulses    = out_if.left_pulses;
      n_results++;
      if (pending_cmds.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
      end else begin
        exp_cmd = pending_cmds.pop_front();
        if (got.right_angle_q8 !== exp_cmd.right_angle_q8) begin
          $error("right_angle_q8 exp %0d got %0d", exp_cmd.right_angle_q8,
                 got.right_angle_q8);
          n_errors++;
        end
        if (got.left_angle_q8 !== exp_cmd.left_angle_q8) begin
          $error("left_angle_q8 exp %0d got %0d", exp_cmd.left_angle_q8,
                 got.left_angle_q8);
          n_errors++;
        end
        if (got.right_pulses !== exp_cmd.right_pulses) begin
          $error("right_pulses exp %0d got %0d", exp_cmd.right_pulses,
                 got.right_pulses);
          n_errors++;
        end
        if (got.left_pulses !== exp_cmd.left_pulses) begin
          $error("left_pulses exp %0d got %0d", exp_cmd.left_pulses,
                 got.left_pulses);
          n_errors++;
        end
      end
    end
  end

  initial begin
    yaw_row_t   rows[$];
    yaw_row_t   row;
    wheel_cmd_t none;
    logic [19:0] phase_cfg[NPHASE][3];
    logic signed [7:0] yaw;
    logic signed [7:0] dir_yaw[13];

    none = '0;
    n_errors  = 0;
    n_results = 0;
    n_sent    = 0;
    calm      = 1'b0;
    wheelbase = 300;
    track     = 250;
    dpp       = 7373;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_WHEELBASE;
    cfg_wdata_i   = '0;
    in_if.valid   = 1'b0;
    in_if.yaw_deg = '0;
    out_if.ready  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero yaw, saturation, extremes, small angles
    rows.push_back('{8'sd0, 1'b1, none});
    dir_yaw = '{8'sd127, -8'sd128, 8'sd89, -8'sd89, 8'sd90, -8'sd90, 8'sd1, -8'sd1,
                8'sd45, -8'sd45, 8'sd30, -8'sd60, 8'sd0};
    foreach (dir_yaw[i]) rows.push_back('{dir_yaw[i], 1'b0, none});
    foreach (rows[i]) begin
      row = rows[i];
      send_yaw(row.yaw, row.typed, row.want);
    end
    drain();

    // index outside the register map must be ignored
    write_reg(2'd3, 20'hFFFFF);
    phase_cfg[0] = '{20'd300, 20'd250, 20'd7373};
    phase_cfg[1] = '{20'd4095, 20'd1, 20'd64};
    phase_cfg[2] = '{20'd1, 20'd4095, 20'hFFFFF};
    phase_cfg[3] = '{20'd100, 20'd4095, 20'd0};
    phase_cfg[4] = '{20'd4095, 20'd4095, 20'd1};
    for (int p = 5; p < NPHASE; p++)
      phase_cfg[p] = '{20'($urandom_range(1, 4095)), 20'($urandom_range(1, 4095)),
                       20'($urandom_range(64, 1048575))};

    for (int p = 0; p < NPHASE; p++) begin
      write_reg(CFG_WHEELBASE, phase_cfg[p][0]);
      write_reg(CFG_TRACK, phase_cfg[p][1]);
      write_reg(CFG_DPP, phase_cfg[p][2]);
      calm = (p == 2);
      for (int k = 0; k < PER_PHASE; k++) begin
        if ($urandom_range(9) == 0) yaw = 8'($urandom);
        else yaw = 8'($signed($urandom_range(0, 178)) - 89);
        send_yaw(yaw, 1'b0, none);
        if (k == PER_PHASE / 2) begin
          in_if.valid <= 1'b0;
          wait (pending_cmds.size() == 0);
          @(negedge clk_i);
        end
      end
      drain();
    end
    calm = 1'b0;

    $display("sent %0d yaw commands over %0d register settings, %0d results checked",
             n_sent, NPHASE + 1, n_results);
    $display("covered zero yaw, saturation, register extremes and zero pulse size");
    if (n_errors == 0 && pending_cmds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
